// ----- rtl/core/adpcm_4bit_frame_decoder_assert.svh -----
// assertion macros shared by the checker
`ifndef ADPCM_4BIT_FRAME_DECODER_ASSERT_SVH
`define ADPCM_4BIT_FRAME_DECODER_ASSERT_SVH

// pre at one edge implies post at the same edge
`define A4FD_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// pre at one edge implies post at the next edge
`define A4FD_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/a4fd_pkg.sv -----
`default_nettype none

package a4fd_pkg;

  localparam int unsigned NumPairs  = 8;
  localparam int unsigned PairSelW  = 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AccW      = 35;
  localparam int unsigned FracBits  = 11;

  localparam logic signed [AccW-1:0]    RoundHalf = 35'sh400;
  localparam logic signed [SampleW-1:0] SatMin    = 16'sh8000;
  localparam logic signed [SampleW-1:0] SatMax    = 16'sh7fff;

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StAdd2 = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  typedef struct packed {
    logic init;
    logic mul_en;
    logic sel;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/adpcm_4bit_frame_decoder.sv -----
// 4-bit ADPCM frame decoder, eight-byte frames with a header byte.
// Input stream s_axis: tuser is op (0 stream byte, 1 load history and
// restart at a header), tdata carries the byte and the two history values.
// Output stream m_axis: one 16-bit sample per word, tlast on the second
// sample of a byte. Coefficient pairs are written over the cfg channel,
// which is always ready; indexes above seven are dropped.
// Header and history words give no output.
// A data byte is decoded as two nibbles in series, each using the one
// shared 16x16 multiplier twice (c1*newest, c2*older), two accumulates,
// then saturation into the output register. s_axis_tready is low while a
// byte is in progress, so the next word waits until both of its samples
// have been loaded into the output register.
// The output register holds a sample until taken; while it is full the
// sequencer waits before loading the next one, so a stalled receiver
// stalls the decoder and no word is lost.
// Reset clears coefficients, history, scale, pair select and frame
// position (the next byte is taken as a header).
`default_nettype none

module adpcm_4bit_frame_decoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // byte_value[7:0], history_newest[23:8], history_older[39:24]
  input  wire logic [a4fd_pkg::InDataW-1:0]        s_axis_tdata,
  // op
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // sample[15:0]
  output logic [a4fd_pkg::SampleW-1:0]             m_axis_tdata,
  output logic                                     m_axis_tlast,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [a4fd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [a4fd_pkg::CfgDataW-1:0]       cfg_data_i
);

  logic [2:0]                          state_q, state_d;
  logic [2:0]                          frame_pos_q, frame_pos_d;
  logic [3:0]                          scale_q, scale_d;
  logic [a4fd_pkg::PairSelW-1:0]       pair_q, pair_d;
  logic signed [a4fd_pkg::SampleW-1:0] prev_q, prev_d, pprev_q, pprev_d;
  logic [7:0]                          byte_q, byte_d;
  logic                                nib_sel_q, nib_sel_d;
  logic                                out_valid_q, out_valid_d;
  logic [a4fd_pkg::SampleW-1:0]        out_data_q, out_data_d;
  logic                                out_last_q, out_last_d;

  logic signed [a4fd_pkg::SampleW-1:0] c1, c2, y;
  logic [3:0]                          nibble;
  a4fd_pkg::mac_ctrl_t                 mac_ctrl;

  assign cfg_ready_o = 1'b1;

  a4fd_coef_regs u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .rd_sel_i  (pair_q),
    .c1_o      (c1),
    .c2_o      (c2)
  );

  assign nibble = nib_sel_q ? byte_q[3:0] : byte_q[7:4];

  a4fd_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .nibble_i (nibble),
    .shift_i  (scale_q),
    .c1_i     (c1),
    .c2_i     (c2),
    .prev_i   (prev_q),
    .pprev_i  (pprev_q),
    .sample_o (y)
  );

  assign s_axis_tready = (state_q == a4fd_pkg::StIdle);

  always_comb begin
    state_d     = state_q;
    frame_pos_d = frame_pos_q;
    scale_d     = scale_q;
    pair_d      = pair_q;
    prev_d      = prev_q;
    pprev_d     = pprev_q;
    byte_d      = byte_q;
    nib_sel_d   = nib_sel_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mac_ctrl    = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      a4fd_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            prev_d      = $signed(s_axis_tdata[23:8]);
            pprev_d     = $signed(s_axis_tdata[39:24]);
            frame_pos_d = 3'd0;
          end else if (frame_pos_q == 3'd0) begin
            scale_d     = s_axis_tdata[3:0];
            pair_d      = s_axis_tdata[6:4];
            frame_pos_d = 3'd1;
          end else begin
            byte_d    = s_axis_tdata[7:0];
            nib_sel_d = 1'b0;
            state_d   = a4fd_pkg::StMul1;
          end
        end
      end
      a4fd_pkg::StMul1: begin
        mac_ctrl.init   = 1'b1;
        mac_ctrl.mul_en = 1'b1;
        state_d         = a4fd_pkg::StMul2;
      end
      a4fd_pkg::StMul2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sel    = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        state_d         = a4fd_pkg::StAdd2;
      end
      a4fd_pkg::StAdd2: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = a4fd_pkg::StOut;
      end
      a4fd_pkg::StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = y;
          out_last_d  = nib_sel_q;
          pprev_d     = prev_q;
          prev_d      = y;
          if (!nib_sel_q) begin
            nib_sel_d = 1'b1;
            state_d   = a4fd_pkg::StMul1;
          end else begin
            frame_pos_d = frame_pos_q + 3'd1;
            state_d     = a4fd_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = a4fd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= a4fd_pkg::StIdle;
      frame_pos_q <= 3'd0;
      scale_q     <= 4'd0;
      pair_q      <= '0;
      prev_q      <= '0;
      pprev_q     <= '0;
      nib_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_pos_q <= frame_pos_d;
      scale_q     <= scale_d;
      pair_q      <= pair_d;
      prev_q      <= prev_d;
      pprev_q     <= pprev_d;
      nib_sel_q   <= nib_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/a4fd_coef_regs.sv -----
`default_nettype none

module a4fd_coef_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 wr_en_i,
  input  wire logic [a4fd_pkg::CfgIdxW-1:0]         wr_idx_i,
  input  wire logic [a4fd_pkg::CfgDataW-1:0]        wr_data_i,
  input  wire logic [a4fd_pkg::PairSelW-1:0]        rd_sel_i,
  output logic signed [a4fd_pkg::SampleW-1:0]       c1_o,
  output logic signed [a4fd_pkg::SampleW-1:0]       c2_o
);

  logic [a4fd_pkg::CfgDataW-1:0] pair_q [a4fd_pkg::NumPairs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < a4fd_pkg::NumPairs; i++) begin
        pair_q[i] <= '0;
      end
    end else if (wr_en_i && (wr_idx_i < a4fd_pkg::CfgIdxW'(a4fd_pkg::NumPairs))) begin
      pair_q[wr_idx_i[a4fd_pkg::PairSelW-1:0]] <= wr_data_i;
    end
  end

  assign c1_o = $signed(pair_q[rd_sel_i][31:16]);
  assign c2_o = $signed(pair_q[rd_sel_i][15:0]);

endmodule

`default_nettype wire

// ----- rtl/core/a4fd_mac.sv -----
`default_nettype none

module a4fd_mac (
  input  wire logic                                clk_i,
  input  wire a4fd_pkg::mac_ctrl_t                 ctrl_i,
  input  wire logic [3:0]                          nibble_i,
  input  wire logic [3:0]                          shift_i,
  input  wire logic signed [a4fd_pkg::SampleW-1:0] c1_i,
  input  wire logic signed [a4fd_pkg::SampleW-1:0] c2_i,
  input  wire logic signed [a4fd_pkg::SampleW-1:0] prev_i,
  input  wire logic signed [a4fd_pkg::SampleW-1:0] pprev_i,
  output logic signed [a4fd_pkg::SampleW-1:0]      sample_o
);

  localparam int unsigned AccW  = a4fd_pkg::AccW;
  localparam int unsigned ProdW = 2 * a4fd_pkg::SampleW;
  localparam int unsigned ShW   = AccW - a4fd_pkg::FracBits;

  logic signed [a4fd_pkg::SampleW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]             prod_d, prod_q;
  logic signed [AccW-1:0]              nib_ext, base, acc_q;
  logic [4:0]                          sh_amt;
  logic signed [ShW-1:0]               shifted;

  assign op_a   = ctrl_i.sel ? c2_i : c1_i;
  assign op_b   = ctrl_i.sel ? pprev_i : prev_i;
  assign prod_d = op_a * op_b;

  assign nib_ext = {{(AccW-4){nibble_i[3]}}, nibble_i};
  assign sh_amt  = {1'b0, shift_i} + 5'(a4fd_pkg::FracBits);
  assign base    = (nib_ext <<< sh_amt) + a4fd_pkg::RoundHalf;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.init) begin
      acc_q <= base;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  // floor shift then saturate
  assign shifted = acc_q[AccW-1:a4fd_pkg::FracBits];

  always_comb begin
    if (shifted < ShW'(a4fd_pkg::SatMin)) begin
      sample_o = a4fd_pkg::SatMin;
    end else if (shifted > ShW'(a4fd_pkg::SatMax)) begin
      sample_o = a4fd_pkg::SatMax;
    end else begin
      sample_o = shifted[a4fd_pkg::SampleW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/a4fd_checker.sv -----
`default_nettype none

`include "adpcm_4bit_frame_decoder_assert.svh"

module a4fd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [a4fd_pkg::SampleW-1:0]    m_axis_tdata,
  input wire logic                            m_axis_tlast,
  input wire logic                            cfg_ready_o
);

  // a stalled word stays valid
  `A4FD_ASSERT_NEXT(out_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a stalled word keeps its data
  `A4FD_ASSERT_NEXT(out_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // while the first sample of a pair is out, the byte is still in progress
  `A4FD_ASSERT_NOW(pair_busy, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // config channel never back-pressures
  `A4FD_ASSERT_NOW(cfg_always_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)

endmodule

bind adpcm_4bit_frame_decoder a4fd_checker u_a4fd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic OpByte        = 1'b0;
  localparam logic OpLoadHistory = 1'b1;
  localparam int   FrameLen      = 8;
  localparam int   MaxReports    = 40;
  localparam int   DrainCycles   = 24;
  localparam int   StallLimit    = 4000;
  localparam int   PhaseItems    = 290;
  localparam int   HoldCycles    = 600;

  typedef struct {
    logic        op;
    logic [7:0]  byte_value;
    logic [15:0] newest;
    logic [15:0] older;
  } stream_item_t;

  typedef enum {CoefRealistic, CoefRandom, CoefMax, CoefMin, CoefZero} coef_set_e;

  class pcm_scoreboard;
    typedef struct {
      logic signed [15:0] sample;
      logic               last;
    } pcm_word_t;

    logic [31:0]        coef_pair [a4fd_pkg::NumPairs];
    int unsigned        frame_pos;
    logic [3:0]         scale_shift;
    logic [2:0]         pair_sel;
    logic signed [15:0] hist_new;
    logic signed [15:0] hist_old;
    pcm_word_t          pending_samples [$];
    int                 errors;
    int                 words_checked;
    int                 items_noted;
    int                 history_loads;

    function new();
      foreach (coef_pair[i]) coef_pair[i] = '0;
      frame_pos     = 0;
      scale_shift   = '0;
      pair_sel      = '0;
      hist_new      = '0;
      hist_old      = '0;
      errors        = 0;
      words_checked = 0;
      items_noted   = 0;
      history_loads = 0;
    endfunction

    function void write_coef(logic [7:0] idx, logic [31:0] val);
      if (idx < a4fd_pkg::NumPairs) coef_pair[idx[2:0]] = val;
    endfunction

    // one filter evaluation, history shifts along
    function logic signed [15:0] next_sample(logic [3:0] nib);
      longint c1, c2, acc, y;
      c1  = $signed(coef_pair[pair_sel][31:16]);
      c2  = $signed(coef_pair[pair_sel][15:0]);
      acc = (longint'($signed(nib)) <<< (scale_shift + a4fd_pkg::FracBits))
          + longint'(a4fd_pkg::RoundHalf) + c1 * hist_new + c2 * hist_old;
      y   = acc >>> a4fd_pkg::FracBits;
      if (y < longint'(a4fd_pkg::SatMin)) y = a4fd_pkg::SatMin;
      else if (y > longint'(a4fd_pkg::SatMax)) y = a4fd_pkg::SatMax;
      hist_old = hist_new;
      hist_new = y[15:0];
      return hist_new;
    endfunction

    function void note_word(logic op, logic [a4fd_pkg::InDataW-1:0] data);
      pcm_word_t  w;
      logic [7:0] b;
      items_noted++;
      b = data[7:0];
      if (op == OpLoadHistory) begin
        hist_new  = data[23:8];
        hist_old  = data[39:24];
        frame_pos = 0;
        history_loads++;
      end else if (frame_pos == 0) begin
        scale_shift = b[3:0];
        pair_sel    = b[6:4];
        frame_pos   = 1;
      end else begin
        w.sample = next_sample(b[7:4]);
        w.last   = 1'b0;
        pending_samples.push_back(w);
        w.sample = next_sample(b[3:0]);
        w.last   = 1'b1;
        pending_samples.push_back(w);
        frame_pos = (frame_pos + 1) % FrameLen;
      end
    endfunction

    function void flag(string field, longint exp_v, longint act_v);
      errors++;
      if (errors <= MaxReports)
        $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
    endfunction

    function void check_word(logic [15:0] data, logic last);
      pcm_word_t w;
      words_checked++;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $error("sample %0d (last %0b) arrived with none expected", $signed(data), last);
        return;
      end
      w = pending_samples.pop_front();
      if ($signed(data) !== w.sample) flag("sample", w.sample, $signed(data));
      if (last !== w.last) flag("last_of_pair", w.last, last);
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [a4fd_pkg::InDataW-1:0]       s_axis_tdata;
  logic                               s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [a4fd_pkg::SampleW-1:0]       m_axis_tdata;
  logic                               m_axis_tlast;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [a4fd_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [a4fd_pkg::CfgDataW-1:0]      cfg_data_i;

  pcm_scoreboard sb = new();
  int            stall_cycles = 0;
  bit            tx_gaps_on = 1'b1;

  adpcm_4bit_frame_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // word monitor and stall counter
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      if (cfg_valid_i && cfg_ready_o) sb.write_coef(cfg_index_i, cfg_data_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin : sample_sink
    int gap;
    int taken;
    bit held;
    bit gaps_on;
    taken   = 0;
    held    = 1'b0;
    gaps_on = 1'b1;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 48 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      gap = gaps_on ? $urandom_range(0, 15) : 0;
      // long hold-off so the decoder backs up into its input
      if (!held && sb.words_checked >= 300) begin
        gap  = HoldCycles;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  function automatic stream_item_t byte_word(logic [7:0] b);
    stream_item_t it;
    it.op         = OpByte;
    it.byte_value = b;
    it.newest     = 16'($urandom);
    it.older      = 16'($urandom);
    return it;
  endfunction

  function automatic stream_item_t history_word(logic [15:0] n, logic [15:0] o, logic [7:0] b);
    stream_item_t it;
    it.op         = OpLoadHistory;
    it.byte_value = b;
    it.newest     = n;
    it.older      = o;
    return it;
  endfunction

  function automatic logic [15:0] pick_history();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_header();
    logic [3:0] shift;
    shift = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    return {1'($urandom), 3'($urandom), shift};
  endfunction

  // mostly whole frames, some history loads and truncated frames
  task automatic build_stream(int n, ref stream_item_t q[$]);
    int r;
    int k;
    while (q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        q.push_back(history_word(pick_history(), pick_history(), 8'($urandom)));
      end else begin
        q.push_back(byte_word(pick_header()));
        k = (r < 14) ? $urandom_range(0, 6) : FrameLen - 1;
        repeat (k) q.push_back(byte_word(8'($urandom)));
      end
    end
  endtask

  task automatic send_items(ref stream_item_t q[$]);
    int gap;
    foreach (q[i]) begin
      if (i % 48 == 0) tx_gaps_on = ($urandom_range(0, 2) != 0);
      gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= q[i].op;
      s_axis_tdata  <= {q[i].older, q[i].newest, q[i].byte_value};
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_coefs(coef_set_e s);
    logic [31:0] v;
    for (int i = 0; i < a4fd_pkg::NumPairs; i++) begin
      case (s)
        CoefRealistic: v = {16'($urandom_range(0, 4095)), 16'(-$urandom_range(0, 2048))};
        CoefRandom:    v = $urandom;
        CoefMax:       v = 32'h7fff_7fff;
        CoefMin:       v = 32'h8000_8000;
        default:       v = '0;
      endcase
      cfg_write(8'(i), v);
    end
    // out-of-range index, dropped
    cfg_write(8'($urandom_range(a4fd_pkg::NumPairs, 255)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    // let the monitor note the last accepted word first
    @(posedge clk_i);
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    stream_item_t items [$];
    coef_set_e    plan [6];
    plan = '{CoefRealistic, CoefRandom, CoefMax, CoefMin, CoefZero, CoefRealistic};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpByte;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(8'd0, 32'h7fff_8000);
    cfg_write(8'd1, 32'h8000_7fff);
    cfg_write(8'd3, 32'h0800_fc00);
    cfg_write(8'd7, 32'hffff_ffff);
    cfg_write(8'd8, 32'h1234_5678);
    cfg_write(8'hff, 32'hffff_ffff);
    cfg_valid_i <= 1'b0;

    // extreme history, header with bit 7 set and largest shift
    items.push_back(history_word(16'h7fff, 16'h8000, 8'hff));
    items.push_back(byte_word(8'h8f));
    items.push_back(byte_word(8'h87));
    items.push_back(byte_word(8'h00));
    // restart in the middle of a frame
    items.push_back(history_word(16'h8000, 16'h7fff, 8'h00));
    items.push_back(byte_word(8'h70));
    items.push_back(byte_word(8'hf1));
    items.push_back(byte_word(8'h7f));
    items.push_back(byte_word(8'h80));
    items.push_back(byte_word(8'h08));
    items.push_back(byte_word(8'hff));
    items.push_back(byte_word(8'h5a));
    items.push_back(byte_word(8'ha5));
    // frame complete, next byte is a header again
    items.push_back(byte_word(8'h3c));
    items.push_back(byte_word(8'h12));
    items.push_back(history_word(16'h0000, 16'h0000, 8'h55));
    items.push_back(byte_word(8'h10));
    items.push_back(byte_word(8'h00));
    items.push_back(byte_word(8'hff));
    send_items(items);
    drain();

    foreach (plan[p]) begin
      items.delete();
      load_coefs(plan[p]);
      build_stream(PhaseItems, items);
      send_items(items);
      drain();
    end

    $display("covered %0d input words (%0d history loads) over %0d coefficient sets",
             sb.items_noted, sb.history_loads, 7);
    $display("checked %0d output samples, %0d errors", sb.words_checked, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/a4fd_pkg.sv
rtl/core/a4fd_coef_regs.sv
rtl/core/a4fd_mac.sv
rtl/core/adpcm_4bit_frame_decoder.sv
rtl/core/a4fd_checker.sv
tb/tb.sv
